// ===== rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros used by the checker file
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent
`define ASSERT_SAME(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed: same-cycle check");

// Consequent must hold in the cycle after the antecedent
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed: next-cycle check");

`endif

// ===== rtl/scc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scc_pkg
// Widths, constants and the per-pixel summary record of the stereo cost
// confidence block.
// ----------------------------------------------------------------------------
package scc_pkg;

	localparam int COST_W = 15;
	localparam int NUM_W  = 9;
	localparam int POS_W  = 9;
	localparam int CNT_W  = 10;
	localparam int EXP_W  = 17;
	localparam int SUM_W  = 25;
	localparam int LIKE_W = 16;

	localparam logic [COST_W-1:0] COST_MAX  = 15'h7FFF;
	localparam logic [SUM_W-1:0]  SUM_MAX   = 25'h1FF_FFFF;
	localparam logic [NUM_W-1:0]  NUM_RESET = 9'd64;
	localparam logic [CNT_W-1:0]  MAX_DISP  = 10'd256;
	localparam logic [LIKE_W-1:0] LIKE_SAT  = 16'hFFFF;

	// Q0.32 decay per table step, floor(2^32 * exp(-1/200))
	localparam logic [31:0] EXP_STEP = 32'd4273546057;

	// diff * 256 / 480 == (diff * 8) / 15
	localparam int CURVE_DIV   = 15;
	localparam int CURVE_SHIFT = 22;
	localparam int CURVE_X_W   = COST_W + 3;
	localparam int RECIP_W     = 19;
	localparam logic [RECIP_W-1:0] CURVE_RECIP = RECIP_W'((64'd1 << CURVE_SHIFT) / CURVE_DIV);

	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = 2;

	// Summary of one pixel handed from the front to the back end
	typedef struct packed {
		logic [COST_W-1:0] best_cost;
		logic [COST_W-1:0] second_cost;
		logic [COST_W-1:0] left_cost;
		logic [COST_W-1:0] right_cost;
		logic [EXP_W-1:0]  min_exp;
		logic [SUM_W-1:0]  exp_sum;
	} pix_rec_t;

endpackage

// ===== rtl/scc_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scc_front
// Builds the exp table after reset, then takes one cost word per cycle while
// the summary queue has room, tracks minimum, runner-up, neighbours and exp
// sum, and pushes one pixel summary at the last disparity.
// ----------------------------------------------------------------------------
module scc_front #(
	parameter int EXP_TABLE_DEPTH = 4096
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_we,
	input  logic [scc_pkg::NUM_W-1:0]  cfg_wdata,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  logic [scc_pkg::COST_W-1:0] in_cost,
	input  logic [scc_pkg::QPTR_W:0]   q_count,
	output logic                       push_valid,
	output scc_pkg::pix_rec_t          push_rec
);

	localparam int AW = $clog2(EXP_TABLE_DEPTH);
	localparam logic [AW-1:0] LAST_IDX = AW'(EXP_TABLE_DEPTH - 1);
	localparam logic [scc_pkg::COST_W-1:0] DEPTH_C = scc_pkg::COST_W'(EXP_TABLE_DEPTH);

	typedef enum logic [2:0] {
		F_MUL  = 3'b001,
		F_STEP = 3'b010,
		F_RUN  = 3'b100
	} fill_state_t;

	fill_state_t fill_state_q;
	logic [AW-1:0] fill_idx_q;
	logic [32:0]   v_q;
	logic [63:0]   prod_q;
	logic [33:0]   v_round;
	logic          wr_en;
	logic [scc_pkg::EXP_W-1:0] exp_mem [EXP_TABLE_DEPTH];

	// Table fill: one entry per F_MUL/F_STEP pair, one 32x32 product per entry
	assign v_round = {1'b0, v_q} + 34'h0_0000_8000;
	assign wr_en   = (fill_state_q == F_MUL);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_state_q <= F_MUL;
			fill_idx_q   <= '0;
			v_q          <= 33'h1_0000_0000;
		end else begin
			unique case (fill_state_q)
				F_MUL: begin
					fill_state_q <= F_STEP;
				end
				F_STEP: begin
					v_q <= (v_q[32] ? {1'b0, scc_pkg::EXP_STEP} : 33'd0) + {1'b0, prod_q[63:32]};
					if (fill_idx_q == LAST_IDX) begin
						fill_state_q <= F_RUN;
					end else begin
						fill_idx_q   <= fill_idx_q + AW'(1);
						fill_state_q <= F_MUL;
					end
				end
				F_RUN: begin
					fill_state_q <= F_RUN;
				end
				default: begin
					fill_state_q <= F_MUL;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		prod_q <= 64'(v_q[31:0]) * 64'(scc_pkg::EXP_STEP);
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			exp_mem[fill_idx_q] <= v_round[32:16];
		end
	end

	// Stage 1: register the cost and its table entry
	logic                       accept;
	logic                       valid_s1;
	logic [scc_pkg::COST_W-1:0] cost_s1;
	logic [scc_pkg::EXP_W-1:0]  exp_s1;

	assign in_ready = (fill_state_q == F_RUN)
		&& (({1'b0, q_count} + {{(scc_pkg::QPTR_W + 1){1'b0}}, valid_s1})
			< (scc_pkg::QPTR_W + 2)'(scc_pkg::QUEUE_DEPTH));
	assign accept = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cost_s1 <= in_cost;
			exp_s1  <= (in_cost < DEPTH_C) ? exp_mem[in_cost[AW-1:0]] : '0;
		end
	end

	// Configuration register
	logic [scc_pkg::NUM_W-1:0] num_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_q <= scc_pkg::NUM_RESET;
		end else if (cfg_we) begin
			num_q <= cfg_wdata;
		end
	end

	// Pixel state
	logic [scc_pkg::POS_W-1:0]  pos_q;
	logic [scc_pkg::COST_W-1:0] best_q, runner_q, left_q, right_q, prev_q;
	logic [scc_pkg::EXP_W-1:0]  best_exp_q;
	logic [scc_pkg::SUM_W-1:0]  sum_q;
	logic                       pending_q;

	logic [scc_pkg::CNT_W-1:0]  cnt_eff;
	logic                       last;
	logic [scc_pkg::COST_W-1:0] best_d, runner_d, left_d, right_d;
	logic [scc_pkg::EXP_W-1:0]  best_exp_d;
	logic                       pending_d;
	logic [scc_pkg::SUM_W:0]    sum_wide;
	logic [scc_pkg::SUM_W-1:0]  sum_d;

	// Effective count: zero acts as one, clamped to the supported range
	always_comb begin
		cnt_eff = {1'b0, num_q};
		if (num_q == '0) begin
			cnt_eff = scc_pkg::CNT_W'(1);
		end else if (cnt_eff > scc_pkg::MAX_DISP) begin
			cnt_eff = scc_pkg::MAX_DISP;
		end
	end

	assign last = (({1'b0, pos_q} + scc_pkg::CNT_W'(1)) >= cnt_eff);

	// Update of minimum, runner-up, neighbours and exp sum for the stage-1 word
	always_comb begin
		best_d     = best_q;
		runner_d   = runner_q;
		left_d     = left_q;
		right_d    = right_q;
		best_exp_d = best_exp_q;
		pending_d  = pending_q;
		if (pending_q) begin
			right_d   = cost_s1;
			pending_d = 1'b0;
		end
		priority if (pos_q == '0 || cost_s1 < best_q) begin
			runner_d   = (pos_q == '0) ? scc_pkg::COST_MAX : best_q;
			best_d     = cost_s1;
			best_exp_d = exp_s1;
			left_d     = (pos_q == '0) ? cost_s1 : prev_q;
			right_d    = cost_s1;
			pending_d  = !last;
		end else if (cost_s1 < runner_q) begin
			runner_d = cost_s1;
		end else begin
			runner_d = runner_q;
		end
		sum_wide = {1'b0, sum_q} + (scc_pkg::SUM_W + 1)'(exp_s1);
		sum_d    = sum_wide[scc_pkg::SUM_W] ? scc_pkg::SUM_MAX : sum_wide[scc_pkg::SUM_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q      <= '0;
			best_q     <= scc_pkg::COST_MAX;
			runner_q   <= scc_pkg::COST_MAX;
			left_q     <= '0;
			right_q    <= '0;
			prev_q     <= '0;
			best_exp_q <= '0;
			sum_q      <= '0;
			pending_q  <= 1'b0;
		end else if (valid_s1) begin
			if (last) begin
				pos_q     <= '0;
				best_q    <= scc_pkg::COST_MAX;
				runner_q  <= scc_pkg::COST_MAX;
				left_q    <= '0;
				right_q   <= '0;
				prev_q    <= '0;
				sum_q     <= '0;
				pending_q <= 1'b0;
			end else begin
				pos_q     <= pos_q + scc_pkg::POS_W'(1);
				best_q    <= best_d;
				runner_q  <= runner_d;
				left_q    <= left_d;
				right_q   <= right_d;
				prev_q    <= cost_s1;
				sum_q     <= sum_d;
				pending_q <= pending_d;
			end
			best_exp_q <= best_exp_d;
		end
	end

	// Summary word toward the queue
	assign push_valid           = valid_s1 && last;
	assign push_rec.best_cost   = best_d;
	assign push_rec.second_cost = runner_d;
	assign push_rec.left_cost   = left_d;
	assign push_rec.right_cost  = right_d;
	assign push_rec.min_exp     = best_exp_d;
	assign push_rec.exp_sum     = sum_d;

endmodule

// ===== rtl/scc_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scc_queue
// Small FIFO of pixel summaries between the front and the back end.
// ----------------------------------------------------------------------------
module scc_queue (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     push_valid,
	input  scc_pkg::pix_rec_t        push_rec,
	output logic                     pop_valid,
	input  logic                     pop_ready,
	output scc_pkg::pix_rec_t        pop_rec,
	output logic [scc_pkg::QPTR_W:0] count
);

	scc_pkg::pix_rec_t             slot_q [scc_pkg::QUEUE_DEPTH];
	logic [scc_pkg::QPTR_W-1:0]    wr_ptr_q, rd_ptr_q;
	logic [scc_pkg::QPTR_W:0]      count_q;
	logic                          do_pop;

	assign pop_valid = (count_q != '0);
	assign pop_rec   = slot_q[rd_ptr_q];
	assign count     = count_q;
	assign do_pop    = pop_valid && pop_ready;

	// Pointers and fill level; the front never pushes into a full queue
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push_valid) begin
				wr_ptr_q <= wr_ptr_q + scc_pkg::QPTR_W'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + scc_pkg::QPTR_W'(1);
			end
			unique case ({push_valid, do_pop})
				2'b10:   count_q <= count_q + (scc_pkg::QPTR_W + 1)'(1);
				2'b01:   count_q <= count_q - (scc_pkg::QPTR_W + 1)'(1);
				default: count_q <= count_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (push_valid) begin
			slot_q[wr_ptr_q] <= push_rec;
		end
	end

endmodule

// ===== rtl/scc_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scc_back
// Turns one pixel summary into the result word: curve confidence through a
// reciprocal multiply, likelihood confidence through a radix-2 divider.
// ----------------------------------------------------------------------------
module scc_back (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       rec_valid,
	output logic                       rec_ready,
	input  scc_pkg::pix_rec_t          rec,
	output logic                       out_valid,
	input  logic                       out_ready,
	output logic [scc_pkg::COST_W-1:0] best_cost,
	output logic [scc_pkg::COST_W-1:0] second_cost,
	output logic [scc_pkg::COST_W-1:0] curve_confidence,
	output logic [scc_pkg::LIKE_W-1:0] likelihood_confidence
);

	localparam int PROD_W = scc_pkg::CURVE_X_W + scc_pkg::RECIP_W;
	localparam int STEP_W = $clog2(scc_pkg::LIKE_W);
	localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(scc_pkg::LIKE_W - 1);

	typedef enum logic [2:0] {
		B_IDLE = 3'b001,
		B_DIV  = 3'b010,
		B_OUT  = 3'b100
	} back_state_t;

	back_state_t state_q;
	logic [STEP_W-1:0]              step_q;
	logic [scc_pkg::COST_W-1:0]     min_q, second_q, curve_q;
	logic [scc_pkg::LIKE_W-1:0]     like_q, quo_q;
	logic [scc_pkg::CURVE_X_W-1:0]  x_q;
	logic [PROD_W-1:0]              cprod_q;
	logic [scc_pkg::SUM_W-1:0]      rem_q, sum_q;
	logic                           sat_q, zero_q;

	logic [scc_pkg::COST_W-1:0]     nb, diff;
	logic [scc_pkg::SUM_W:0]        rem_x2, rem_sub;
	logic                           qbit;
	logic [scc_pkg::LIKE_W-1:0]     quo_d;
	logic [scc_pkg::COST_W-1:0]     cq;
	logic [scc_pkg::CURVE_X_W:0]    cq15, cres;

	// Larger neighbour minus minimum, clipped at zero
	assign nb   = (rec.left_cost > rec.right_cost) ? rec.left_cost : rec.right_cost;
	assign diff = (nb > rec.best_cost) ? (nb - rec.best_cost) : '0;

	// One restoring division step per cycle
	assign rem_x2  = {rem_q, 1'b0};
	assign qbit    = (rem_x2 >= {1'b0, sum_q});
	assign rem_sub = rem_x2 - {1'b0, sum_q};
	assign quo_d   = {quo_q[scc_pkg::LIKE_W-2:0], qbit};

	// Reciprocal estimate is low by at most one; fix with one compare
	assign cq   = cprod_q[scc_pkg::CURVE_SHIFT +: scc_pkg::COST_W];
	assign cq15 = ({4'b0, cq} << 4) - {4'b0, cq};
	assign cres = {1'b0, x_q} - cq15;

	assign rec_ready = (state_q == B_IDLE);
	assign out_valid = (state_q == B_OUT);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= B_IDLE;
			step_q  <= '0;
		end else begin
			unique case (state_q)
				B_IDLE: begin
					step_q <= '0;
					if (rec_valid) begin
						state_q <= B_DIV;
					end
				end
				B_DIV: begin
					step_q <= step_q + STEP_W'(1);
					if (step_q == LAST_STEP) begin
						state_q <= B_OUT;
					end
				end
				B_OUT: begin
					if (out_ready) begin
						state_q <= B_IDLE;
					end
				end
				default: begin
					state_q <= B_IDLE;
				end
			endcase
		end
	end

	// Datapath
	always_ff @(posedge clk) begin
		if (state_q == B_IDLE && rec_valid) begin
			min_q    <= rec.best_cost;
			second_q <= rec.second_cost;
			x_q      <= {diff, 3'b000};
			rem_q    <= scc_pkg::SUM_W'(rec.min_exp);
			sum_q    <= rec.exp_sum;
			quo_q    <= '0;
			zero_q   <= (rec.exp_sum == '0);
			sat_q    <= (scc_pkg::SUM_W'(rec.min_exp) >= rec.exp_sum);
		end
		if (state_q == B_DIV) begin
			rem_q <= qbit ? rem_sub[scc_pkg::SUM_W-1:0] : rem_x2[scc_pkg::SUM_W-1:0];
			quo_q <= quo_d;
			if (step_q == '0) begin
				cprod_q <= PROD_W'(x_q) * PROD_W'(scc_pkg::CURVE_RECIP);
			end
			if (step_q == STEP_W'(1)) begin
				curve_q <= (cres >= (scc_pkg::CURVE_X_W + 1)'(scc_pkg::CURVE_DIV))
					? (cq + scc_pkg::COST_W'(1)) : cq;
			end
			if (step_q == LAST_STEP) begin
				priority if (zero_q) begin
					like_q <= '0;
				end else if (sat_q) begin
					like_q <= scc_pkg::LIKE_SAT;
				end else begin
					like_q <= quo_d;
				end
			end
		end
	end

	assign best_cost             = min_q;
	assign second_cost           = second_q;
	assign curve_confidence      = curve_q;
	assign likelihood_confidence = like_q;

endmodule

// ===== rtl/stereo_cost_confidence_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stereo_cost_confidence_top
// Per-pixel matching confidence from a stream of disparity costs.
// ----------------------------------------------------------------------------
// Channel   Direction  Word
// s_axis    in         cost [14:0]
// m_axis    out        min, second min, curve conf, likelihood conf
// cfg       in         num_disparities [8:0], write-only
//
// Cost words are taken one per cycle while the summary queue has room. After its
// last cost, a pixel's summary passes the stage-1 register and the queue, is
// loaded into the back end and runs through the radix-2 likelihood divider
// before its result is offered. The back end holds each word until taken, loading
// no new summary before then; the four-entry queue lets the front keep going while
// results stall. s_axis_tready is low while the exp table fills after reset.
// ----------------------------------------------------------------------------
module stereo_cost_confidence_top #(
	parameter int EXP_TABLE_DEPTH = 4096
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [8:0]  cfg_wdata,      // num_disparities
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [15:0] s_axis_tdata,   // [14:0] cost, [15] zero
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [63:0] m_axis_tdata    // [14:0] lowest cost, [29:15] second cost,
	                                    // [44:30] curve_confidence,
	                                    // [60:45] likelihood_confidence, [63:61] zero
);

	scc_pkg::pix_rec_t             push_rec, pop_rec;
	logic                          push_valid, pop_valid, pop_ready;
	logic [scc_pkg::QPTR_W:0]      q_count;
	logic [scc_pkg::COST_W-1:0]    best_cost, second_cost, curve_confidence;
	logic [scc_pkg::LIKE_W-1:0]    likelihood_confidence;

	scc_front #(
		.EXP_TABLE_DEPTH(EXP_TABLE_DEPTH)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_wdata  (cfg_wdata),
		.in_valid   (s_axis_tvalid),
		.in_ready   (s_axis_tready),
		.in_cost    (s_axis_tdata[14:0]),
		.q_count    (q_count),
		.push_valid (push_valid),
		.push_rec   (push_rec)
	);

	scc_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_rec   (push_rec),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_rec    (pop_rec),
		.count      (q_count)
	);

	scc_back u_back (
		.clk                   (clk),
		.arst_n                (arst_n),
		.rec_valid             (pop_valid),
		.rec_ready             (pop_ready),
		.rec                   (pop_rec),
		.out_valid             (m_axis_tvalid),
		.out_ready             (m_axis_tready),
		.best_cost             (best_cost),
		.second_cost           (second_cost),
		.curve_confidence      (curve_confidence),
		.likelihood_confidence (likelihood_confidence)
	);

	// Result word packing
	assign m_axis_tdata = {3'b000, likelihood_confidence, curve_confidence,
		second_cost, best_cost};

endmodule

// ===== rtl/scc_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scc_checker
// Port-level checks of the stereo cost confidence block, bound to the top.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module scc_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        m_axis_tvalid,
	input logic        m_axis_tready,
	input logic [63:0] m_axis_tdata
);

	// A stalled result word stays offered and unchanged
	`ASSERT_NEXT(a_out_hold, clk, arst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid)
	`ASSERT_NEXT(a_out_stable, clk, arst_n, m_axis_tvalid && !m_axis_tready, $stable(m_axis_tdata))

	// Minimum never exceeds the runner-up
	`ASSERT_SAME(a_min_order, clk, arst_n, m_axis_tvalid, m_axis_tdata[14:0] <= m_axis_tdata[29:15])

	// Curve confidence stays at or below 17476, the ceiling of (32767 * 256) / 480
	`ASSERT_SAME(a_curve_range, clk, arst_n, m_axis_tvalid, m_axis_tdata[44:30] <= 15'd17476)

endmodule

bind stereo_cost_confidence_top scc_checker u_scc_checker (.*);
